[hw/rtl/scpd_pkg.sv]
// Shared types and constants for the sync checksum packet deframer.
`timescale 1ns / 1ps

package scpd_pkg;

    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 6;
    localparam int PKT_CNT_W = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_VALUE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_SEED = 1'b1;

    localparam logic [BYTE_W-1:0] SYNC_VALUE_RST    = 8'd85;
    localparam logic [BYTE_W-1:0] CHECKSUM_SEED_RST = 8'd170;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic take;
        logic scan_start;
        logic scan_run;
        logic scan_end;
        logic emit_start;
        logic emit_run;
    } cmd_t;

    typedef struct packed {
        logic is_last;
        logic sum_ok;
        logic scan_done;
        logic emit_done;
    } status_t;

endpackage

[hw/rtl/scpd_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module scpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 9
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/scpd_ctrl.sv]
// Controller state machine: input acceptance, resync scan and packet emission.
`timescale 1ns / 1ps

module scpd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  scpd_pkg::status_t status,
    output scpd_pkg::cmd_t    cmd
);

    import scpd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.take = in_valid;
                if (in_valid && status.is_last)
                begin
                    if (status.sum_ok)
                    begin
                        cmd.emit_start = 1'b1;
                        state_next     = ST_EMIT;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (status.scan_done)
                begin
                    cmd.scan_end = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                cmd.emit_run = 1'b1;
                if (status.emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/scpd_datapath.sv]
// Datapath: config registers, body buffer, checksum, resync copy and output register.
`timescale 1ns / 1ps

module scpd_datapath #(
    parameter int PACKET_SIZE = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  scpd_pkg::cmd_t                        cmd,
    output scpd_pkg::status_t                     status,
    input  logic                                  cfg_write,
    input  logic [scpd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [scpd_pkg::BYTE_W-1:0]           cfg_data,
    input  logic [scpd_pkg::BYTE_W-1:0]           rx_byte,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [scpd_pkg::BYTE_W-1:0]           packet_byte,
    output logic [scpd_pkg::IDX_W-1:0]            byte_index,
    output logic                                  last_byte,
    output logic [scpd_pkg::PKT_CNT_W-1:0]        packet_number
);

    import scpd_pkg::*;

    localparam int BODY_LEN = PACKET_SIZE - 1;
    localparam int AW       = $clog2(BODY_LEN);
    localparam int CW       = $clog2(BODY_LEN + 1);

    logic [BYTE_W-1:0]    sync_reg, sync_next;
    logic [BYTE_W-1:0]    seed_reg, seed_next;
    logic                 hunting_reg, hunting_next;
    logic [AW-1:0]        fill_reg, fill_next;
    logic [BYTE_W-1:0]    sum_reg, sum_next;
    logic [PKT_CNT_W-1:0] count_reg, count_next;
    logic                 found_reg, found_next;
    logic [AW-1:0]        wp_reg, wp_next;
    logic [CW-1:0]        ra_reg, ra_next;
    logic                 pv_reg, pv_next;
    logic [AW-1:0]        rd_idx_reg, rd_idx_next;

    logic                 out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]    out_byte_reg, out_byte_next;
    logic [IDX_W-1:0]     out_idx_reg, out_idx_next;
    logic                 out_last_reg, out_last_next;
    logic [PKT_CNT_W-1:0] out_num_reg, out_num_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [BYTE_W-1:0]    ram_wdata;
    logic                 ram_re;
    logic [BYTE_W-1:0]    ram_rdata;

    logic [BYTE_W-1:0]    chk_sum;
    logic                 reads_left;
    logic                 load;

    scpd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BODY_LEN)
    ) u_body_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ra_reg[AW-1:0]),
        .rd_data (ram_rdata)
    );

    assign chk_sum    = seed_reg + sum_reg;
    assign reads_left = (ra_reg != CW'(BODY_LEN));
    assign load       = cmd.emit_run && pv_reg && (!out_valid_reg || !out_stall);

    assign status.is_last   = !hunting_reg && (fill_reg == AW'(BODY_LEN - 1));
    assign status.sum_ok    = (chk_sum == rx_byte);
    assign status.scan_done = !reads_left && !pv_reg;
    assign status.emit_done = !reads_left && !pv_reg;

    always_comb
    begin
        sync_next      = sync_reg;
        seed_next      = seed_reg;
        hunting_next   = hunting_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        found_next     = found_reg;
        wp_next        = wp_reg;
        ra_next        = ra_reg;
        pv_next        = pv_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        out_num_next   = out_num_reg;
        ram_we         = 1'b0;
        ram_waddr      = fill_reg;
        ram_wdata      = rx_byte;
        ram_re         = 1'b0;

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SYNC_VALUE:    sync_next = cfg_data;
                CFG_CHECKSUM_SEED: seed_next = cfg_data;
            endcase
        end

        // incoming byte: leave hunt on sync, otherwise store and accumulate
        if (cmd.take)
        begin
            if (hunting_reg)
            begin
                if (rx_byte == sync_reg)
                begin
                    hunting_next = 1'b0;
                    fill_next    = '0;
                    sum_next     = '0;
                end
            end
            else
            begin
                ram_we    = 1'b1;
                fill_next = fill_reg + 1'b1;
                sum_next  = sum_reg + rx_byte;
            end
        end

        if (cmd.emit_start)
        begin
            count_next   = count_reg + 1'b1;
            hunting_next = 1'b1;
            fill_next    = '0;
            ra_next      = '0;
            pv_next      = 1'b0;
        end

        if (cmd.scan_start)
        begin
            ra_next    = '0;
            pv_next    = 1'b0;
            found_next = 1'b0;
            wp_next    = '0;
            sum_next   = '0;
        end

        // resync: drop bytes up to the first sync, move the rest to the front
        if (cmd.scan_run && pv_reg)
        begin
            pv_next = 1'b0;
            if (!found_reg)
            begin
                if (ram_rdata == sync_reg)
                begin
                    found_next = 1'b1;
                end
            end
            else
            begin
                ram_we    = 1'b1;
                ram_waddr = wp_reg;
                ram_wdata = ram_rdata;
                wp_next   = wp_reg + 1'b1;
                sum_next  = sum_reg + ram_rdata;
            end
        end

        if (cmd.scan_end)
        begin
            fill_next    = wp_reg;
            hunting_next = !found_reg;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (load)
        begin
            pv_next        = 1'b0;
            out_valid_next = 1'b1;
            out_byte_next  = ram_rdata;
            out_idx_next   = IDX_W'(rd_idx_reg);
            out_last_next  = (rd_idx_reg == AW'(BODY_LEN - 1));
            out_num_next   = count_reg;
        end

        if (reads_left && (cmd.scan_run || (cmd.emit_run && (!pv_reg || load))))
        begin
            ram_re      = 1'b1;
            pv_next     = 1'b1;
            rd_idx_next = ra_reg[AW-1:0];
            ra_next     = ra_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg      <= SYNC_VALUE_RST;
            seed_reg      <= CHECKSUM_SEED_RST;
            hunting_reg   <= 1'b1;
            fill_reg      <= '0;
            count_reg     <= '0;
            ra_reg        <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sync_reg      <= sync_next;
            seed_reg      <= seed_next;
            hunting_reg   <= hunting_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            ra_reg        <= ra_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        found_reg    <= found_next;
        wp_reg       <= wp_next;
        rd_idx_reg   <= rd_idx_next;
        out_byte_reg <= out_byte_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
        out_num_reg  <= out_num_next;
    end

    assign out_valid     = out_valid_reg;
    assign packet_byte   = out_byte_reg;
    assign byte_index    = out_idx_reg;
    assign last_byte     = out_last_reg;
    assign packet_number = out_num_reg;

endmodule

[hw/rtl/sync_checksum_packet_deframer.sv]
// Top level of the sync checksum packet deframer.
`timescale 1ns / 1ps

// Receives one byte per input beat. While hunting, bytes are dropped until one
// matches sync_value; the next PACKET_SIZE-1 bytes form the body, whose final
// byte must equal checksum_seed plus all earlier body bytes, modulo 256. A good
// body leaves as PACKET_SIZE-1 output beats with byte_index, a last_byte mark on
// the checksum byte and the running good-packet count in packet_number. A bad
// body is rescanned for its first sync byte and the bytes after it are kept as
// the start of the next packet; with no sync byte inside, the block hunts again.
// A byte that does not complete a body is taken without holding the input. A byte
// that completes a good body holds the input while the body is read out of the
// buffer RAM one beat per cycle while out_stall is low. A bad body holds the
// input while the scan walks the buffer RAM one entry per cycle through its
// single read port.
module sync_checksum_packet_deframer #(
    parameter int PACKET_SIZE = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [scpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [scpd_pkg::BYTE_W-1:0]        cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [scpd_pkg::BYTE_W-1:0]        rx_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [scpd_pkg::BYTE_W-1:0]        packet_byte,
    output logic [scpd_pkg::IDX_W-1:0]         byte_index,
    output logic                               last_byte,
    output logic [scpd_pkg::PKT_CNT_W-1:0]     packet_number
);

    import scpd_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequence each beat: accept, resync scan, or body readout.
    scpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold the registers, buffer, running sum and output register.
    scpd_datapath #(
        .PACKET_SIZE (PACKET_SIZE)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .packet_byte   (packet_byte),
        .byte_index    (byte_index),
        .last_byte     (last_byte),
        .packet_number (packet_number)
    );

endmodule

[dv/tb_sync_checksum_packet_deframer.sv]
// Self-checking testbench for the sync checksum packet deframer.
`timescale 1ns / 1ps

module tb_sync_checksum_packet_deframer;

    import scpd_pkg::*;

    localparam int PKT_SIZE      = 10;
    localparam int BODY_LEN      = PKT_SIZE - 1;
    // A bad body scan or a good body read-out holds the block; settle for
    // SETTLE_CYCLES before touching the registers.
    localparam int SETTLE_CYCLES = 2 * PKT_SIZE + 4;
    // Cycles with no beat on either side before the run is declared hung.
    localparam int HANG_LIMIT    = 3000;

    // One output beat of a good packet.
    typedef struct packed {
        logic [BYTE_W-1:0]    data;
        logic [IDX_W-1:0]     index;
        logic                 last;
        logic [PKT_CNT_W-1:0] count;
    } body_beat_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SYNC_VALUE;
    logic [BYTE_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [BYTE_W-1:0]    rx_byte = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [BYTE_W-1:0]    packet_byte;
    logic [IDX_W-1:0]     byte_index;
    logic                 last_byte;
    logic [PKT_CNT_W-1:0] packet_number;

    // Bytes waiting for the driver, and packet beats waiting for the monitor.
    logic [BYTE_W-1:0]    rx_stream [$];
    body_beat_t           pending_packet_beats [$];

    // Idling knobs, in percent of cycles.
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   error_count = 0;
    int                   packet_bytes_sent = 0;
    int                   quiet_cycles = 0;

    // Shadow of the deframer: registers and state as they stand after reset.
    logic [BYTE_W-1:0]    sync_reg = SYNC_VALUE_RST;
    logic [BYTE_W-1:0]    seed_reg = CHECKSUM_SEED_RST;
    logic [BYTE_W-1:0]    body_mem [BODY_LEN];
    int                   fill_cnt = 0;
    logic                 hunting = 1'b1;
    logic [PKT_CNT_W-1:0] good_cnt = '0;

    sync_checksum_packet_deframer #(
        .PACKET_SIZE (PKT_SIZE)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .packet_byte   (packet_byte),
        .byte_index    (byte_index),
        .last_byte     (last_byte),
        .packet_number (packet_number)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the shadow deframer by one accepted byte and queue the beats
    // of a packet that passes its checksum.
    function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] sum;
        int                pos;
        int                keep;
        body_beat_t        beat;

        // Hunting: drop everything up to and including the sync byte.
        if (hunting)
        begin
            if (b == sync_reg)
            begin
                hunting  = 1'b0;
                fill_cnt = 0;
            end
            return;
        end

        body_mem[fill_cnt] = b;
        fill_cnt++;
        if (fill_cnt < BODY_LEN)
            return;

        sum = seed_reg;
        for (int i = 0; i < BODY_LEN - 1; i++)
            sum = sum + body_mem[i];

        if (sum != body_mem[BODY_LEN-1])
        begin
            // Bad body: restart on the first sync byte inside it, keeping
            // whatever followed that byte as the head of the next body.
            pos = -1;
            for (int p = 0; p < BODY_LEN; p++)
                if (pos < 0 && body_mem[p] == sync_reg)
                    pos = p;
            if (pos >= 0)
            begin
                keep = BODY_LEN - 1 - pos;
                for (int k = 0; k < keep; k++)
                    body_mem[k] = body_mem[k + pos + 1];
                fill_cnt = keep;
            end
            else
            begin
                fill_cnt = 0;
                hunting  = 1'b1;
            end
            return;
        end

        // Good body: the count advances first, every beat carries the new value.
        good_cnt = good_cnt + 1'b1;
        for (int i = 0; i < BODY_LEN; i++)
        begin
            beat.data  = body_mem[i];
            beat.index = IDX_W'(i);
            beat.last  = (i == BODY_LEN - 1);
            beat.count = good_cnt;
            pending_packet_beats.push_back(beat);
        end
        fill_cnt = 0;
        hunting  = 1'b1;
    endfunction

    // Driver: present the next byte, hold it while stalled, idle at random.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                deframe_byte(rx_byte);
            if (!in_valid || !in_stall)
            begin
                if (rx_stream.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= rx_stream.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: stall at random and check every accepted beat against the
    // oldest beat still owed.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_packet_beats.size() == 0)
            begin
                $display("%0t: unexpected beat: packet_byte %h byte_index %0d",
                         $time, packet_byte, byte_index);
                $display("%0t: unexpected beat: last_byte %b packet_number %0d",
                         $time, last_byte, packet_number);
                error_count++;
            end
            else
            begin
                body_beat_t want;
                want = pending_packet_beats.pop_front();
                if (packet_byte !== want.data)
                begin
                    $display("%0t: packet_byte expected %h actual %h", $time, want.data, packet_byte);
                    error_count++;
                end
                if (byte_index !== want.index)
                begin
                    $display("%0t: byte_index expected %0d actual %0d", $time, want.index, byte_index);
                    error_count++;
                end
                if (last_byte !== want.last)
                begin
                    $display("%0t: last_byte expected %b actual %b", $time, want.last, last_byte);
                    error_count++;
                end
                if (packet_number !== want.count)
                begin
                    $display("%0t: packet_number expected %0d actual %0d",
                             $time, want.count, packet_number);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: give up once neither side has moved a beat for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, HANG_LIMIT);
                $display("** sync_checksum_packet_deframer: FAILED **");
                $finish;
            end
        end
    end

    // Write one register; the shadow copy follows at once since the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_SYNC_VALUE)
            sync_reg = value;
        else if (idx == CFG_CHECKSUM_SEED)
            seed_reg = value;
    endtask

    // Queue a body: the leading bytes, then the checksum byte offset by
    // spoil (zero gives a good body).
    task automatic push_body(input logic [BYTE_W-1:0] lead [BODY_LEN-1],
                             input logic [BYTE_W-1:0] spoil);
        logic [BYTE_W-1:0] sum;
        sum = seed_reg;
        for (int i = 0; i < BODY_LEN - 1; i++)
        begin
            rx_stream.push_back(lead[i]);
            sum = sum + lead[i];
        end
        rx_stream.push_back(sum + spoil);
        packet_bytes_sent += BODY_LEN;
    endtask

    // Queue one random unit of traffic: mostly good packets, some with a
    // broken head that forces a restart inside the body, some with a bad
    // checksum, and runs of line noise.
    task automatic push_random_unit();
        logic [BYTE_W-1:0] lead [BODY_LEN-1];
        logic [BYTE_W-1:0] b;
        int                roll;
        int                gap;
        roll = $urandom_range(99);
        if (roll < 15)
        begin
            gap = $urandom_range(5, 1);
            for (int i = 0; i < gap; i++)
                rx_stream.push_back(BYTE_W'($urandom_range(255)));
            packet_bytes_sent += gap;
            return;
        end
        for (int i = 0; i < BODY_LEN - 1; i++)
            lead[i] = BYTE_W'($urandom_range(255));
        rx_stream.push_back(sync_reg);
        packet_bytes_sent++;
        if (roll < 30)
        begin
            // Broken head: a sync-free prefix, then the real sync and body.
            // The prefix plus the new body fill the first body, fail its
            // checksum in almost every case, and restart on the inner sync.
            gap = $urandom_range(BODY_LEN - 1, 0);
            for (int i = 0; i < gap; i++)
            begin
                b = BYTE_W'($urandom_range(255));
                rx_stream.push_back((b == sync_reg) ? ~b : b);
            end
            rx_stream.push_back(sync_reg);
            packet_bytes_sent += gap + 1;
        end
        push_body(lead, (roll >= 80) ? BYTE_W'($urandom_range(255, 1)) : '0);
    endtask

    // Hold until every byte is taken and every packet beat has arrived,
    // then let an unfinished scan run out.
    task automatic drain();
        while (rx_stream.size() != 0 || in_valid || pending_packet_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(input int n_bytes, input int idle_pct, input int stall_pct);
        send_idle_pct     = idle_pct;
        recv_stall_pct    = stall_pct;
        packet_bytes_sent = 0;
        while (packet_bytes_sent < n_bytes)
            push_random_unit();
        drain();
    endtask

    initial
    begin
        logic [BYTE_W-1:0] lead [BODY_LEN-1];

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset settings (sync 0x55, seed 0xAA).
        // Line noise while hunting.
        rx_stream.push_back(8'h00);
        // Bad checksum with no sync byte inside: back to hunting.
        rx_stream.push_back(sync_reg);
        lead = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h10, 8'h20};
        push_body(lead, 8'd1);
        // Sync byte inside a bad body: restart there, and the bytes that
        // follow complete a good packet without a new sync.
        rx_stream.push_back(sync_reg);
        rx_stream.push_back(8'hFF);
        rx_stream.push_back(8'h00);
        rx_stream.push_back(sync_reg);
        lead = '{8'hAA, 8'h33, 8'hCC, 8'h0F, 8'hF0, 8'h11, 8'h80, 8'h01};
        push_body(lead, '0);
        drain();

        // Random phases, each with its own settings and idling.
        run_random(100, 0, 0);

        write_reg(CFG_SYNC_VALUE, 8'h00);
        write_reg(CFG_CHECKSUM_SEED, 8'hFF);
        run_random(100, 79, 0);

        write_reg(CFG_SYNC_VALUE, 8'hFF);
        write_reg(CFG_CHECKSUM_SEED, 8'h00);
        run_random(100, 0, 79);

        write_reg(CFG_SYNC_VALUE, BYTE_W'($urandom_range(255)));
        write_reg(CFG_CHECKSUM_SEED, BYTE_W'($urandom_range(255)));
        run_random(100, 35, 35);

        if (error_count == 0)
            $display("** sync_checksum_packet_deframer: PASSED **");
        else
            $display("** sync_checksum_packet_deframer: FAILED **");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/scpd_pkg.sv
hw/rtl/scpd_ram.sv
hw/rtl/scpd_ctrl.sv
hw/rtl/scpd_datapath.sv
hw/rtl/sync_checksum_packet_deframer.sv
dv/tb_sync_checksum_packet_deframer.sv
